// ===== rtl/atw_pkg.sv =====
// ----------------------------------------------------------------------------
// atw_pkg
// Shared types, codes and helpers for the two-level page table walker.
// ----------------------------------------------------------------------------
`default_nettype none

package atw_pkg;

  // register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MMU_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_PROTECT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_PROTECT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_ACCESS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN     = 3'd5;

  // default queue depths
  localparam int unsigned ITEM_QUEUE_DEPTH   = 2;
  localparam int unsigned RESULT_QUEUE_DEPTH = 2;

  // input command codes
  localparam logic CMD_REQUEST    = 1'b0;
  localparam logic CMD_DESCRIPTOR = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FAULT = 2'd2;

  // granted access levels
  localparam logic [1:0] ACC_NONE = 2'd0;
  localparam logic [1:0] ACC_RO   = 2'd1;
  localparam logic [1:0] ACC_RW   = 2'd2;

  // abort kinds
  localparam logic [1:0] ABT_NONE     = 2'd0;
  localparam logic [1:0] ABT_PREFETCH = 2'd1;
  localparam logic [1:0] ABT_DATA     = 2'd2;

  // domain access values
  localparam logic [1:0] DAV_NONE     = 2'd0;
  localparam logic [1:0] DAV_CLIENT   = 2'd1;
  localparam logic [1:0] DAV_RESERVED = 2'd2;
  localparam logic [1:0] DAV_MANAGER  = 2'd3;

  // descriptor type codes
  localparam logic [1:0] DESC_FAULT  = 2'd0;
  localparam logic [1:0] DESC_COARSE = 2'd1;
  localparam logic [1:0] DESC_SECT   = 2'd2;
  localparam logic [1:0] DESC_FINE   = 2'd3;
  localparam logic [1:0] DESC_LARGE  = 2'd1;
  localparam logic [1:0] DESC_SMALL  = 2'd2;
  localparam logic [1:0] DESC_TINY   = 2'd3;

  // fault codes
  localparam logic [3:0] FLT_SECT_TRANS = 4'd5;
  localparam logic [3:0] FLT_PAGE_TRANS = 4'd7;
  localparam logic [3:0] FLT_SECT_DOM   = 4'd9;
  localparam logic [3:0] FLT_PAGE_DOM   = 4'd11;
  localparam logic [3:0] FLT_SECT_PERM  = 4'd13;
  localparam logic [3:0] FLT_PAGE_PERM  = 4'd15;

  // configuration registers
  typedef struct packed {
    logic        mmu_enable;
    logic        system_protect;
    logic        rom_protect;
    logic [31:0] table_base;
    logic [31:0] domain_access;
    logic        big_endian;
  } cfg_t;

  // request flags kept for the walk
  typedef struct packed {
    logic no_exc;
    logic user;
    logic write;
    logic instr;
  } flags_t;

  // classified request between front and back
  typedef struct packed {
    logic        cmd;
    logic [31:0] vaddr;
    flags_t      flags;
    logic [31:0] desc;
  } item_t;

  // one result
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [1:0]  access;
    logic [1:0]  abort;
    logic [7:0]  fault_status;
    logic [31:0] fault_address;
  } result_t;

  // access level from ap bits, domain access value and the S/R bits
  function automatic logic [1:0] level_for(input logic [1:0] ap, input logic [1:0] dav,
                                           input logic user, input logic s_bit,
                                           input logic r_bit);
    logic [1:0] lvl;
    lvl = ACC_NONE;
    if (dav == DAV_NONE || dav == DAV_RESERVED) begin
      lvl = ACC_NONE;
    end else if (dav == DAV_MANAGER) begin
      lvl = ACC_RW;
    end else begin
      unique case (ap)
        2'd0: begin
          if (s_bit && !r_bit) lvl = user ? ACC_NONE : ACC_RO;
          else if (!s_bit && r_bit) lvl = ACC_RO;
          else lvl = ACC_NONE;
        end
        2'd1: lvl = user ? ACC_NONE : ACC_RW;
        2'd2: lvl = user ? ACC_RO : ACC_RW;
        default: lvl = ACC_RW;
      endcase
    end
    return lvl;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/atw_fifo.sv =====
// ----------------------------------------------------------------------------
// atw_fifo
// Small register queue with count, used between the walker stages.
// ----------------------------------------------------------------------------
`default_nettype none

module atw_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      pop_data,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/atw_front.sv =====
// ----------------------------------------------------------------------------
// atw_front
// Accepts requests, packs flags, assembles descriptor bytes and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module atw_front #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          big_endian,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire logic          in_cmd,
  input  wire logic [31:0]   in_vaddr,
  input  wire logic          in_is_instr,
  input  wire logic          in_is_write,
  input  wire logic          in_user_mode,
  input  wire logic          in_user_access,
  input  wire logic          in_silent_fault,
  input  wire logic [31:0]   in_descriptor_bytes,
  output atw_pkg::item_t     item,
  output logic               item_empty,
  input  wire logic          item_pop
);

  import atw_pkg::*;

  item_t                item_in;
  logic [$bits(item_t)-1:0] head;

  // classify the request
  always_comb begin
    item_in.cmd          = in_cmd;
    item_in.vaddr        = in_vaddr;
    item_in.flags.instr  = in_is_instr;
    item_in.flags.write  = in_is_write;
    item_in.flags.user   = in_user_mode | in_user_access;
    item_in.flags.no_exc = in_silent_fault;
    if (big_endian) begin
      item_in.desc = {in_descriptor_bytes[7:0], in_descriptor_bytes[15:8],
                      in_descriptor_bytes[23:16], in_descriptor_bytes[31:24]};
    end else begin
      item_in.desc = in_descriptor_bytes;
    end
  end

  // queue toward the walker
  atw_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (DEPTH)
  ) u_item_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (item_in),
    .full      (in_full),
    .pop       (item_pop),
    .pop_data  (head),
    .empty     (item_empty)
  );

  assign item = item_t'(head);

endmodule

`default_nettype wire

// ===== rtl/atw_back.sv =====
// ----------------------------------------------------------------------------
// atw_back
// Walk FSM: handles one request per cycle if results have room; forms results.
// ----------------------------------------------------------------------------
`default_nettype none

module atw_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire atw_pkg::cfg_t    cfg,
  input  wire atw_pkg::item_t   item,
  input  wire logic             item_empty,
  output logic                  item_pop,
  input  wire logic             res_full,
  output logic                  res_push,
  output atw_pkg::result_t      res
);

  import atw_pkg::*;

  localparam logic [1:0] STAGE_IDLE = 2'd0;
  localparam logic [1:0] STAGE_L1   = 2'd1;
  localparam logic [1:0] STAGE_L2   = 2'd2;

  logic [1:0]  stage_r, stage_nxt;
  logic [31:0] pend_va_r, pend_va_nxt;
  flags_t      pend_flags_r, pend_flags_nxt;
  logic [3:0]  sect_dom_r, sect_dom_nxt;
  logic [1:0]  sect_dav_r, sect_dav_nxt;
  logic [31:0] fault_addr_r, fault_addr_nxt;
  logic [7:0]  fault_status_r, fault_status_nxt;

  logic        has_res;
  logic        do_finish, do_fault;
  logic [31:0] paddr, d, va;
  logic [1:0]  ap, lvl;
  logic [3:0]  f_dom, f_code, perm_code, dom_code;
  logic [7:0]  sub_ap;
  logic [1:0]  sub_sel;

  assign item_pop = !item_empty && !res_full;
  assign res_push = item_pop && has_res;

  // walk step
  always_comb begin
    stage_nxt        = stage_r;
    pend_va_nxt      = pend_va_r;
    pend_flags_nxt   = pend_flags_r;
    sect_dom_nxt     = sect_dom_r;
    sect_dav_nxt     = sect_dav_r;
    fault_addr_nxt   = fault_addr_r;
    fault_status_nxt = fault_status_r;
    has_res          = 1'b0;
    do_finish        = 1'b0;
    do_fault         = 1'b0;
    paddr            = '0;
    ap               = 2'd0;
    f_dom            = 4'd0;
    f_code           = 4'd0;
    perm_code        = FLT_PAGE_PERM;
    dom_code         = FLT_PAGE_DOM;
    lvl              = ACC_NONE;
    d                = item.desc;
    va               = pend_va_r;
    sub_ap           = d[11:4];
    sub_sel          = 2'd0;
    res.kind         = KIND_READ;
    res.address      = '0;
    res.access       = ACC_NONE;
    res.abort        = ABT_NONE;

    if (item.cmd == CMD_REQUEST) begin
      has_res = 1'b1;
      if (!cfg.mmu_enable) begin
        stage_nxt   = STAGE_IDLE;
        res.kind    = KIND_DONE;
        res.address = item.vaddr;
        res.access  = ACC_RW;
      end else begin
        pend_va_nxt    = item.vaddr;
        pend_flags_nxt = item.flags;
        stage_nxt      = STAGE_L1;
        res.address    = cfg.table_base + {18'd0, item.vaddr[31:20], 2'b00};
      end
    end else if (stage_r == STAGE_L1) begin
      // first-level descriptor
      has_res      = 1'b1;
      sect_dom_nxt = d[8:5];
      sect_dav_nxt = cfg.domain_access[{d[8:5], 1'b0} +: 2];
      unique case (d[1:0])
        DESC_COARSE: begin
          stage_nxt   = STAGE_L2;
          res.address = {d[31:10], 10'd0} + {22'd0, va[19:12], 2'b00};
        end
        DESC_SECT: begin
          do_finish = 1'b1;
          paddr     = {d[31:20], va[19:0]};
          ap        = d[11:10];
          dom_code  = FLT_SECT_DOM;
          perm_code = FLT_SECT_PERM;
        end
        default: begin
          do_fault = 1'b1;
          f_dom    = 4'd0;
          f_code   = FLT_SECT_TRANS;
        end
      endcase
    end else if (stage_r == STAGE_L2) begin
      // second-level descriptor
      has_res = 1'b1;
      unique case (d[1:0])
        DESC_LARGE: begin
          do_finish = 1'b1;
          sub_sel   = va[15:14];
          paddr     = {d[31:16], va[15:0]};
          ap        = sub_ap[{sub_sel, 1'b0} +: 2];
        end
        DESC_SMALL: begin
          do_finish = 1'b1;
          sub_sel   = va[11:10];
          paddr     = {d[31:12], va[11:0]};
          ap        = sub_ap[{sub_sel, 1'b0} +: 2];
        end
        DESC_TINY: begin
          do_finish = 1'b1;
          paddr     = {d[31:10], va[9:0]};
          ap        = d[5:4];
        end
        default: begin
          do_fault = 1'b1;
          f_dom    = sect_dom_r;
          f_code   = FLT_PAGE_TRANS;
        end
      endcase
    end else begin
      // descriptor while idle is dropped
      stage_nxt = STAGE_IDLE;
    end

    // domain and permission check
    if (do_finish) begin
      f_dom = sect_dom_nxt;
      if (sect_dav_nxt == DAV_NONE) begin
        do_fault = 1'b1;
        f_code   = dom_code;
      end else begin
        lvl = level_for(ap, sect_dav_nxt, pend_flags_r.user, cfg.system_protect,
                        cfg.rom_protect);
        if (lvl > {1'b0, pend_flags_r.write}) begin
          stage_nxt   = STAGE_IDLE;
          res.kind    = KIND_DONE;
          res.address = paddr;
          res.access  = lvl;
        end else begin
          do_fault = 1'b1;
          f_code   = perm_code;
        end
      end
    end

    // fault reporting
    if (do_fault) begin
      stage_nxt   = STAGE_IDLE;
      res.kind    = KIND_FAULT;
      res.address = '0;
      res.access  = ACC_NONE;
      if (!pend_flags_r.no_exc) begin
        if (pend_flags_r.instr) begin
          res.abort = ABT_PREFETCH;
        end else begin
          res.abort        = ABT_DATA;
          fault_addr_nxt   = pend_va_r;
          fault_status_nxt = {f_dom, f_code};
        end
      end
    end

    res.fault_status  = fault_status_nxt;
    res.fault_address = fault_addr_nxt;
  end

  // walk state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r        <= STAGE_IDLE;
      pend_va_r      <= '0;
      pend_flags_r   <= '0;
      sect_dom_r     <= '0;
      sect_dav_r     <= '0;
      fault_addr_r   <= '0;
      fault_status_r <= '0;
    end else if (item_pop) begin
      stage_r        <= stage_nxt;
      pend_va_r      <= pend_va_nxt;
      pend_flags_r   <= pend_flags_nxt;
      sect_dom_r     <= sect_dom_nxt;
      sect_dav_r     <= sect_dav_nxt;
      fault_addr_r   <= fault_addr_nxt;
      fault_status_r <= fault_status_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/arm_two_level_page_walker.sv =====
// ----------------------------------------------------------------------------
// arm_two_level_page_walker
// Two-level ARM page table walker with queue-style request and result ports.
// ----------------------------------------------------------------------------
// Each push is a new translation request (cmd 0) or a returned descriptor word
// (cmd 1), and yields at most one result: a descriptor read address, a finished
// translation with its access level, or a fault. The block takes one request
// per clock cycle while the result queue has room; a request passes the request
// queue register and the combinational walk step into the result queue
// register, whose head drives the out_ ports until it is popped. When results
// are not popped the result queue fills, the walk step stalls and the request
// queue then fills and raises full.
// Configuration writes are always ready and must only be made while no
// request is in flight.
`default_nettype none

module arm_two_level_page_walker #(
  parameter int unsigned ITEM_DEPTH   = atw_pkg::ITEM_QUEUE_DEPTH,
  parameter int unsigned RESULT_DEPTH = atw_pkg::RESULT_QUEUE_DEPTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [atw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                     cfg_data,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            in_cmd,
  input  wire logic [31:0]                     in_vaddr,
  input  wire logic                            in_is_instr,
  input  wire logic                            in_is_write,
  input  wire logic                            in_user_mode,
  input  wire logic                            in_user_access,
  input  wire logic                            in_silent_fault,
  input  wire logic [31:0]                     in_descriptor_bytes,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [1:0]                           out_kind,
  output logic [31:0]                          out_address,
  output logic [1:0]                           out_access,
  output logic [1:0]                           out_abort,
  output logic [7:0]                           out_fault_status,
  output logic [31:0]                          out_fault_address
);

  import atw_pkg::*;

  cfg_t                       cfg_r;
  item_t                      item;
  logic                       item_empty, item_pop;
  logic                       res_full, res_push;
  result_t                    res, res_head;
  logic [$bits(result_t)-1:0] res_bits;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MMU_ENABLE:     cfg_r.mmu_enable     <= cfg_data[0];
        CFG_SYSTEM_PROTECT: cfg_r.system_protect <= cfg_data[0];
        CFG_ROM_PROTECT:    cfg_r.rom_protect    <= cfg_data[0];
        CFG_TABLE_BASE:     cfg_r.table_base     <= cfg_data;
        CFG_DOMAIN_ACCESS:  cfg_r.domain_access  <= cfg_data;
        CFG_BIG_ENDIAN:     cfg_r.big_endian     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // request intake
  atw_front #(
    .DEPTH (ITEM_DEPTH)
  ) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .big_endian          (cfg_r.big_endian),
    .in_push             (push),
    .in_full             (full),
    .in_cmd              (in_cmd),
    .in_vaddr            (in_vaddr),
    .in_is_instr         (in_is_instr),
    .in_is_write         (in_is_write),
    .in_user_mode        (in_user_mode),
    .in_user_access      (in_user_access),
    .in_silent_fault     (in_silent_fault),
    .in_descriptor_bytes (in_descriptor_bytes),
    .item                (item),
    .item_empty          (item_empty),
    .item_pop            (item_pop)
  );

  // walk step
  atw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  // result queue
  atw_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESULT_DEPTH)
  ) u_result_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (res_bits),
    .empty     (empty)
  );

  assign res_head          = result_t'(res_bits);
  assign out_kind          = res_head.kind;
  assign out_address       = res_head.address;
  assign out_access        = res_head.access;
  assign out_abort         = res_head.abort;
  assign out_fault_status  = res_head.fault_status;
  assign out_fault_address = res_head.fault_address;

endmodule

`default_nettype wire
